// ===== rtl/vtpd_pkg.sv =====
// Package for the vertex transform and perspective divide unit.
// Holds the word types, widths, register indexes and the clip helper.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package vtpd_pkg;

    localparam int CW        = 16;           // coordinate width, Q8.8 at 16
    localparam int FRAC      = 8;            // fraction bits of a coordinate
    localparam int COEF_W    = 16;           // coefficient width, Q4.12
    localparam int COEF_FRAC = 12;
    localparam int NUM_ROWS  = 4;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int PW        = CW + COEF_W;  // one matrix product
    localparam int SW        = PW + 2;       // sum of four products
    localparam int MW        = 2 * CW + 1;   // product of two coordinates, negated
    localparam int QW        = CW + FRAC;    // dividend and quotient magnitude
    localparam int DW        = CW;           // divisor magnitude

    localparam logic signed [SW-1:0] SAT_HI = SW'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
    localparam logic signed [CW-1:0] H_NEG_ONE = CW'(-(1 << FRAC));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0 = 3'd0,
        REG_ROW1 = 3'd1,
        REG_ROW2 = 3'd2,
        REG_ROW3 = 3'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [CW-1:0] coord_x;
        logic signed [CW-1:0] coord_y;
        logic signed [CW-1:0] coord_z;
        logic signed [CW-1:0] coord_h;
    } vertex_t;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic                 saturated;
        logic                 divide_by_zero;
    } result_t;

    // Values that ride alongside the divider lanes.
    typedef struct packed {
        logic                 sign_x;
        logic                 sign_y;
        logic                 below;
        logic                 dz;
        logic                 sat;
        logic signed [CW-1:0] out_z;
        logic signed [CW-1:0] bel_x;
        logic signed [CW-1:0] bel_y;
    } side_t;

    typedef struct packed {
        logic signed [CW-1:0] val;
        logic                 sat;
    } clip_t;

    function automatic clip_t clip_coord(input logic signed [SW-1:0] v);
        clip_t r;
        r.sat = 1'b1;
        if (v > SAT_HI) begin
            r.val = CW'(SAT_HI);
        end else if (v < SAT_LO) begin
            r.val = CW'(SAT_LO);
        end else begin
            r.val = CW'(v);
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vtpd_divider.sv =====
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Carries a side word of flags and values next to the lanes. Uses vtpd_pkg.
`default_nettype none

module vtpd_divider
    import vtpd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [QW-1:0] dividend_x,
    input  wire logic [QW-1:0] dividend_y,
    input  wire logic [DW-1:0] divisor,
    input  wire side_t         side_in,
    output logic               out_valid,
    output logic [QW-1:0]      quot_x,
    output logic [QW-1:0]      quot_y,
    output side_t              side_out
);

    logic          valid_reg [QW];
    logic [DW-1:0] d_reg     [QW];
    side_t         side_reg  [QW];
    logic [DW-1:0] rem_reg   [QW][2];
    logic [QW-1:0] dq_reg    [QW][2];

    logic [DW-1:0] rem_next  [QW][2];
    logic [QW-1:0] dq_next   [QW][2];

    always_comb
    begin
        logic [DW-1:0] rem_src;
        logic [QW-1:0] dq_src;
        logic [DW-1:0] d_src;
        logic [DW:0]   shifted;
        logic [DW+1:0] trial;
        int            kp;
        for (int k = 0; k < QW; k++) begin
            kp = (k == 0) ? 0 : k - 1;
            for (int l = 0; l < 2; l++) begin
                if (k == 0) begin
                    rem_src = '0;
                    dq_src  = (l == 0) ? dividend_x : dividend_y;
                    d_src   = divisor;
                end else begin
                    rem_src = rem_reg[kp][l];
                    dq_src  = dq_reg[kp][l];
                    d_src   = d_reg[kp];
                end
                shifted = {rem_src, dq_src[QW-1]};
                trial   = {1'b0, shifted} - {2'b00, d_src};
                if (!trial[DW+1]) begin
                    rem_next[k][l] = trial[DW-1:0];
                end else begin
                    rem_next[k][l] = shifted[DW-1:0];
                end
                dq_next[k][l] = {dq_src[QW-2:0], ~trial[DW+1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < QW; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < QW; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            d_reg[0]    <= divisor;
            side_reg[0] <= side_in;
            for (int k = 1; k < QW; k++) begin
                d_reg[k]    <= d_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < QW; k++) begin
                for (int l = 0; l < 2; l++) begin
                    rem_reg[k][l] <= rem_next[k][l];
                    dq_reg[k][l]  <= dq_next[k][l];
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quot_x    = dq_reg[QW-1][0];
    assign quot_y    = dq_reg[QW-1][1];
    assign side_out  = side_reg[QW-1];

endmodule

`default_nettype wire

// ===== rtl/vertex_transform_perspective_divide_unit.sv =====
// Top level of the vertex transform and perspective divide unit.
// Holds the matrix registers, the transform stages and the output register.
// Depends on vtpd_pkg and vtpd_divider.
`default_nettype none

// The unit takes one homogeneous vertex word per cycle, multiplies it as a row
// vector by the 4x4 Q4.12 matrix held in four 64-bit registers, and divides the
// transformed x and y by the adjusted h. Every word is independent, so a new
// word enters in every cycle that the output side does not stall; each word
// passes through one stage of sixteen multipliers, one stage of column sums,
// one stage of rounding and clipping, one stage that adjusts h and forms the
// dividends, 24 stages of a restoring divider that yields one quotient bit per
// stage, and the output register. When the output word is held by stall, the
// whole pipeline holds with it, and in_stall follows at once. The user must
// write the matrix through cfg_write_en, cfg_index and cfg_data only while the
// unit is idle; the unit does not enforce it. A write to an index above three
// is ignored. After reset the matrix is the identity.
module vertex_transform_perspective_divide_unit
    import vtpd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire vertex_t              in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output result_t                   out_data,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // Matrix registers, one row per register.
    logic [CFG_W-1:0] row_reg [NUM_ROWS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_ROWS; i++) begin
                row_reg[i] <= CFG_W'(64'd1 << (COEF_FRAC + COEF_W * i));
            end
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                REG_ROW0: row_reg[0] <= cfg_data;
                REG_ROW1: row_reg[1] <= cfg_data;
                REG_ROW2: row_reg[2] <= cfg_data;
                REG_ROW3: row_reg[3] <= cfg_data;
                default:  ;
            endcase
        end
    end

    // The whole pipeline moves only when the output register can take a word.
    logic adv;
    logic out_valid_reg;
    result_t out_data_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Stage 1: the sixteen products v_i * M[i][j].
    logic                 v1_reg;
    logic signed [PW-1:0] prod_reg [NUM_ROWS][NUM_ROWS];
    logic signed [CW-1:0] vin [NUM_ROWS];

    assign vin[0] = in_data.coord_x;
    assign vin[1] = in_data.coord_y;
    assign vin[2] = in_data.coord_z;
    assign vin[3] = in_data.coord_h;

    always_ff @(posedge clk)
    begin
        if (adv) begin
            for (int i = 0; i < NUM_ROWS; i++) begin
                for (int j = 0; j < NUM_ROWS; j++) begin
                    prod_reg[i][j] <= PW'(vin[i])
                                      * PW'($signed(row_reg[i][COEF_W*j +: COEF_W]));
                end
            end
        end
    end

    // Stage 2: column sums.
    logic                 v2_reg;
    logic signed [SW-1:0] acc_reg [NUM_ROWS];

    always_ff @(posedge clk)
    begin
        if (adv) begin
            for (int j = 0; j < NUM_ROWS; j++) begin
                acc_reg[j] <= SW'(prod_reg[0][j]) + SW'(prod_reg[1][j])
                            + SW'(prod_reg[2][j]) + SW'(prod_reg[3][j]);
            end
        end
    end

    // Stage 3: round each sum to eight fraction bits, ties away from zero, and clip.
    logic                 v3_reg;
    logic signed [CW-1:0] t_reg [NUM_ROWS];
    logic                 sat3_reg;
    clip_t                tc [NUM_ROWS];

    always_comb
    begin
        logic [SW-1:0]        mag;
        logic [SW-1:0]        rnd;
        logic signed [SW-1:0] sv;
        for (int j = 0; j < NUM_ROWS; j++) begin
            mag   = acc_reg[j][SW-1] ? SW'(-acc_reg[j]) : SW'(acc_reg[j]);
            rnd   = (mag + (SW'(1) << (COEF_FRAC - 1))) >> COEF_FRAC;
            sv    = acc_reg[j][SW-1] ? -$signed(rnd) : $signed(rnd);
            tc[j] = clip_coord(sv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            for (int j = 0; j < NUM_ROWS; j++) begin
                t_reg[j] <= tc[j].val;
            end
            sat3_reg <= tc[0].sat | tc[1].sat | tc[2].sat | tc[3].sat;
        end
    end

    // Stage 4: adjust h. Below minus one, x / (-1/h) is the product -x*h;
    // otherwise the dividend magnitude |x| * 256 + h'/2 goes to the divider.
    logic                 v4_reg;
    logic signed [MW-1:0] bx_reg, by_reg;
    logic [QW-1:0]        divx_reg, divy_reg;
    logic [DW-1:0]        hd_reg;
    logic                 sx_reg, sy_reg, below_reg, dz_reg, sat4_reg;
    logic signed [CW-1:0] z4_reg;

    logic                 below4;
    logic [DW-1:0]        hd4;
    logic [CW-1:0]        absx4, absy4;

    assign below4 = t_reg[3] < H_NEG_ONE;
    assign hd4    = t_reg[3][CW-1] ? DW'(-t_reg[3]) : DW'(t_reg[3]);
    assign absx4  = t_reg[0][CW-1] ? CW'(-t_reg[0]) : CW'(t_reg[0]);
    assign absy4  = t_reg[1][CW-1] ? CW'(-t_reg[1]) : CW'(t_reg[1]);

    always_ff @(posedge clk)
    begin
        if (adv) begin
            bx_reg    <= -(MW'(t_reg[0]) * MW'(t_reg[3]));
            by_reg    <= -(MW'(t_reg[1]) * MW'(t_reg[3]));
            divx_reg  <= (QW'(absx4) << FRAC) + QW'(hd4 >> 1);
            divy_reg  <= (QW'(absy4) << FRAC) + QW'(hd4 >> 1);
            hd_reg    <= hd4;
            sx_reg    <= t_reg[0][CW-1];
            sy_reg    <= t_reg[1][CW-1];
            below_reg <= below4;
            dz_reg    <= !below4 && (hd4 == '0);
            sat4_reg  <= sat3_reg;
            z4_reg    <= t_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Round the short-path products and pack the values that ride with the divider.
    side_t side_in;
    clip_t cbx, cby;

    always_comb
    begin
        logic [MW-1:0]        magx, magy;
        logic [MW-1:0]        rx, ry;
        logic signed [MW-1:0] svx, svy;
        magx = bx_reg[MW-1] ? MW'(-bx_reg) : MW'(bx_reg);
        magy = by_reg[MW-1] ? MW'(-by_reg) : MW'(by_reg);
        rx   = (magx + (MW'(1) << (FRAC - 1))) >> FRAC;
        ry   = (magy + (MW'(1) << (FRAC - 1))) >> FRAC;
        svx  = bx_reg[MW-1] ? -$signed(rx) : $signed(rx);
        svy  = by_reg[MW-1] ? -$signed(ry) : $signed(ry);
        cbx  = clip_coord(SW'(svx));
        cby  = clip_coord(SW'(svy));
        side_in.sign_x = sx_reg;
        side_in.sign_y = sy_reg;
        side_in.below  = below_reg;
        side_in.dz     = dz_reg;
        side_in.sat    = sat4_reg | (below_reg & (cbx.sat | cby.sat));
        side_in.out_z  = z4_reg;
        side_in.bel_x  = cbx.val;
        side_in.bel_y  = cby.val;
    end

    logic          dv_valid;
    logic [QW-1:0] qx, qy;
    side_t         side_out;

    vtpd_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (v4_reg),
        .dividend_x (divx_reg),
        .dividend_y (divy_reg),
        .divisor    (hd_reg),
        .side_in    (side_in),
        .out_valid  (dv_valid),
        .quot_x     (qx),
        .quot_y     (qy),
        .side_out   (side_out)
    );

    // Final stage: sign the quotients, clip, and choose between the paths.
    result_t res;
    clip_t   cqx, cqy;

    always_comb
    begin
        logic signed [SW-1:0] sqx, sqy;
        sqx = $signed(SW'(qx));
        sqy = $signed(SW'(qy));
        cqx = clip_coord(side_out.sign_x ? -sqx : sqx);
        cqy = clip_coord(side_out.sign_y ? -sqy : sqy);
        res.out_z          = side_out.out_z;
        res.divide_by_zero = side_out.dz;
        priority if (side_out.below) begin
            res.out_x     = side_out.bel_x;
            res.out_y     = side_out.bel_y;
            res.saturated = side_out.sat;
        end else if (side_out.dz) begin
            res.out_x     = '0;
            res.out_y     = '0;
            res.saturated = side_out.sat;
        end else begin
            res.out_x     = cqx.val;
            res.out_y     = cqy.val;
            res.saturated = side_out.sat | cqx.sat | cqy.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A zero divisor always forces x and y to zero.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.divide_by_zero |-> out_data.out_x == '0 && out_data.out_y == '0)
        else $error("divide_by_zero word with nonzero x or y");

    // Input stall is exactly a held output word.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall not tied to output stall");

    // A write to an index above three leaves the matrix untouched.
    a_cfg_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en && cfg_index != REG_ROW0 && cfg_index != REG_ROW1
        && cfg_index != REG_ROW2 && cfg_index != REG_ROW3
        |=> $stable(row_reg[0]) && $stable(row_reg[1])
            && $stable(row_reg[2]) && $stable(row_reg[3]))
        else $error("matrix changed by write beyond the register list");

    // While the output word is held, the pipeline front does not move.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(v1_reg) && $stable(v4_reg))
        else $error("pipeline moved while the output was stalled");

endmodule

`default_nettype wire
